// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the interpolator RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define TLI_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define TLI_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define TLI_ASSERT(label, clk, rstn, prop, msg)
`define TLI_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

// ===== sv/tli_pkg.sv =====
// ----------------------------------------------------------------------------
// tli_pkg
// Constants, codes and interface types of the table interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

    localparam int ROW_W     = 8;
    localparam int COL_W     = 4;
    localparam int MAX_ROWS  = 1 << ROW_W;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int DEPTH     = 1 << ADDR_W;
    localparam int DATA_W    = 32;
    localparam int NROW_W    = ROW_W + 1;
    localparam int SUM_W     = DATA_W + ROW_W;
    localparam int MAG_W     = DATA_W + 1;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int QUOT_W    = 41;
    localparam int STEP_W    = 7;
    localparam int MUL_STEPS = MAG_W;
    localparam int DIV_STEPS = PROD_W;

    localparam logic [2:0] OC_EXACT  = 3'd0;
    localparam logic [2:0] OC_INTERP = 3'd1;
    localparam logic [2:0] OC_EXTRAP = 3'd2;
    localparam logic [2:0] OC_AVG    = 3'd3;
    localparam logic [2:0] OC_ZSTEP  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN0, ST_SCAN, ST_RDA, ST_RDB, ST_CAP,
        ST_AVG0, ST_AVG, ST_DIV, ST_OUT
    } tli_state_t;

    typedef enum logic [1:0] {
        AR_IDLE, AR_MUL, AR_DIV, AR_FIN
    } ar_state_t;

    typedef struct packed {
        logic              start;
        logic              use_mul;
        logic [SUM_W-1:0]  opa;
        logic [MAG_W-1:0]  opb;
        logic [MAG_W-1:0]  divisor;
    } ar_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } ar_rsp_t;

endpackage

// ===== sv/table_linear_interpolator.sv =====
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Piecewise-linear interpolation over a 256 x 16 table of Q16.16 words.
// ----------------------------------------------------------------------------
// A write beat (kind 0) stores entry_value at column_index/row_index and
// gives no result; writes may follow each other every cycle while no query
// is in progress. A query beat (kind 1) gives one result beat. The query
// walks the time column through the single-port table RAM one row per
// cycle (up to rows_in_use rows), reads the two value entries it needs,
// then runs a serial multiply and then a serial divide. A query that falls
// back to the column average walks the column a second time and then runs
// the divide alone. Exact hits and zero time steps skip the multiply and
// divide and finish after the scan and the two reads.
// Only one query is in flight; no new beat is taken until its result is
// loaded into the result register, which lets the next beat be taken while
// an earlier result waits on m_ready. rows_in_use is clamped to 2..256 and
// must be written only while idle. Entries read by a query must have been
// written first; the RAM is not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module table_linear_interpolator (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [tli_pkg::NROW_W-1:0]   cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_kind,
    input  logic [tli_pkg::ROW_W-1:0]    s_row_index,
    input  logic [tli_pkg::COL_W-1:0]    s_column_index,
    input  logic signed [tli_pkg::DATA_W-1:0] s_entry_value,
    input  logic signed [tli_pkg::DATA_W-1:0] s_query_time,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [tli_pkg::DATA_W-1:0] m_result_value,
    output logic [2:0]                   m_outcome
);

    localparam int DW = tli_pkg::DATA_W;
    localparam int RW = tli_pkg::ROW_W;
    localparam int XW = DW + 11;
    localparam logic signed [XW-1:0] RES_MAX = {{(XW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [XW-1:0] RES_MIN = {{(XW-DW+1){1'b1}}, {(DW-1){1'b0}}};

    tli_pkg::tli_state_t state_reg, state_next;

    // configuration
    logic [tli_pkg::NROW_W-1:0] rows_reg;
    logic [tli_pkg::NROW_W-1:0] n_eff;

    // query context
    logic signed [DW-1:0]         time_reg;
    logic [tli_pkg::COL_W-1:0]    col_reg;
    logic [RW-1:0]                k_reg;
    logic signed [DW-1:0]         t1_reg, t2_reg;
    logic [RW-1:0]                va_row_reg, vb_row_reg;
    logic signed [DW-1:0]         va_reg;
    logic [2:0]                   oc_reg;
    logic signed [tli_pkg::SUM_W-1:0] sum_reg;
    logic signed [DW-1:0]         base_reg;
    logic                         neg_reg;
    logic signed [DW-1:0]         fin_val_reg;
    logic [2:0]                   fin_oc_reg;

    // result register
    logic                         m_valid_reg;
    logic signed [DW-1:0]         m_val_reg;
    logic [2:0]                   m_oc_reg;

    // memory port
    logic                         mem_we;
    logic [tli_pkg::ADDR_W-1:0]   mem_addr;
    logic [DW-1:0]                mem_rdata;
    logic signed [DW-1:0]         rd;

    tli_pkg::ar_req_t ar_req;
    tli_pkg::ar_rsp_t ar_rsp;

    // decode of the current cycle
    logic                         s_fire;
    logic                         scan_eq, scan_between, scan_last, scan_past;
    logic                         avg_last;
    logic                         zero_step;
    logic                         out_free;
    logic                         out_load;
    logic                         in_div;
    logic signed [tli_pkg::SUM_W-1:0] sum_next;
    logic signed [DW:0]           dv, dt, step;
    logic [tli_pkg::MAG_W-1:0]    dv_mag, dt_mag, step_mag;
    logic [tli_pkg::SUM_W-1:0]    sum_mag;
    logic signed [XW-1:0]         base_wide, quot_wide;
    logic signed [XW-1:0]         res_wide;
    logic signed [DW-1:0]         res_sat;

    assign rd = $signed(mem_rdata);

    always_comb begin
        n_eff = rows_reg;
        if (rows_reg < tli_pkg::NROW_W'(2)) begin
            n_eff = tli_pkg::NROW_W'(2);
        end else if (rows_reg > tli_pkg::NROW_W'(tli_pkg::MAX_ROWS)) begin
            n_eff = tli_pkg::NROW_W'(tli_pkg::MAX_ROWS);
        end
    end

    always_comb begin
        s_fire       = s_valid && s_ready;
        scan_eq      = rd == time_reg;
        scan_between = (k_reg != '0) && (t2_reg < time_reg) && (rd > time_reg);
        scan_last    = {1'b0, k_reg} == n_eff - 1'b1;
        scan_past    = time_reg > rd;
        sum_next     = sum_reg + tli_pkg::SUM_W'(rd);
        avg_last     = {1'b0, k_reg} == n_eff - 1'b1;
        zero_step    = t1_reg == t2_reg;
        out_free     = !m_valid_reg || m_ready;
        out_load     = (state_reg == tli_pkg::ST_OUT) && out_free;
        in_div       = state_reg == tli_pkg::ST_DIV;
        dv           = {rd[DW-1], rd} - {va_reg[DW-1], va_reg};
        dt           = {time_reg[DW-1], time_reg} - {t2_reg[DW-1], t2_reg};
        step         = {t2_reg[DW-1], t2_reg} - {t1_reg[DW-1], t1_reg};
        dv_mag       = dv[DW]   ? tli_pkg::MAG_W'(-dv)   : tli_pkg::MAG_W'(dv);
        dt_mag       = dt[DW]   ? tli_pkg::MAG_W'(-dt)   : tli_pkg::MAG_W'(dt);
        step_mag     = step[DW] ? tli_pkg::MAG_W'(-step) : tli_pkg::MAG_W'(step);
        sum_mag      = sum_next[tli_pkg::SUM_W-1] ? tli_pkg::SUM_W'(-sum_next)
                                                   : tli_pkg::SUM_W'(sum_next);
    end

    // apply sign and base, then saturate to 32 bits
    always_comb begin
        base_wide = {{(XW-DW){base_reg[DW-1]}}, base_reg};
        quot_wide = {{(XW-tli_pkg::QUOT_W){1'b0}}, ar_rsp.quot};
        res_wide  = neg_reg ? (base_wide - quot_wide) : (base_wide + quot_wide);
        if (res_wide > RES_MAX) begin
            res_sat = {1'b0, {(DW-1){1'b1}}};
        end else if (res_wide < RES_MIN) begin
            res_sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            res_sat = res_wide[DW-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tli_pkg::ST_IDLE: begin
                if (s_fire && s_kind) state_next = tli_pkg::ST_SCAN0;
            end
            tli_pkg::ST_SCAN0: state_next = tli_pkg::ST_SCAN;
            tli_pkg::ST_SCAN: begin
                if (scan_eq || scan_between) begin
                    state_next = tli_pkg::ST_RDA;
                end else if (scan_last) begin
                    state_next = scan_past ? tli_pkg::ST_RDA : tli_pkg::ST_AVG0;
                end
            end
            tli_pkg::ST_RDA:  state_next = tli_pkg::ST_RDB;
            tli_pkg::ST_RDB:  state_next = tli_pkg::ST_CAP;
            tli_pkg::ST_CAP: begin
                if (oc_reg == tli_pkg::OC_EXACT || zero_step) begin
                    state_next = tli_pkg::ST_OUT;
                end else begin
                    state_next = tli_pkg::ST_DIV;
                end
            end
            tli_pkg::ST_AVG0: state_next = tli_pkg::ST_AVG;
            tli_pkg::ST_AVG:  if (avg_last) state_next = tli_pkg::ST_DIV;
            tli_pkg::ST_DIV:  if (ar_rsp.done) state_next = tli_pkg::ST_OUT;
            tli_pkg::ST_OUT:  if (out_free) state_next = tli_pkg::ST_IDLE;
            default:          state_next = tli_pkg::ST_IDLE;
        endcase
    end

    // outputs: memory port, handshake, divider request
    always_comb begin
        s_ready        = state_reg == tli_pkg::ST_IDLE;
        mem_we         = 1'b0;
        mem_addr       = '0;
        ar_req.start   = 1'b0;
        ar_req.use_mul = 1'b1;
        ar_req.opa     = tli_pkg::SUM_W'(dv_mag);
        ar_req.opb     = dt_mag;
        ar_req.divisor = step_mag;
        case (state_reg)
            tli_pkg::ST_IDLE: begin
                mem_we   = s_fire && !s_kind;
                mem_addr = {s_column_index, s_row_index};
            end
            tli_pkg::ST_SCAN0: mem_addr = '0;
            tli_pkg::ST_SCAN:  mem_addr = {tli_pkg::COL_W'(0), k_reg + 1'b1};
            tli_pkg::ST_RDA:   mem_addr = {col_reg, va_row_reg};
            tli_pkg::ST_RDB:   mem_addr = {col_reg, vb_row_reg};
            tli_pkg::ST_CAP: begin
                ar_req.start = oc_reg != tli_pkg::OC_EXACT && !zero_step;
            end
            tli_pkg::ST_AVG0:  mem_addr = {col_reg, RW'(0)};
            tli_pkg::ST_AVG: begin
                mem_addr       = {col_reg, k_reg + 1'b1};
                ar_req.start   = avg_last;
                ar_req.use_mul = 1'b0;
                ar_req.opa     = sum_mag;
                ar_req.divisor = tli_pkg::MAG_W'(n_eff);
            end
            default: begin
            end
        endcase
    end

    tli_ram #(
        .ADDR_W (tli_pkg::ADDR_W),
        .DATA_W (tli_pkg::DATA_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (s_entry_value),
        .rdata (mem_rdata)
    );

    tli_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ar_req),
        .rsp     (ar_rsp)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tli_pkg::ST_IDLE;
            rows_reg    <= tli_pkg::NROW_W'(tli_pkg::MAX_ROWS);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                rows_reg <= cfg_wr_data;
            end
            // load the result beat, or drop it once taken
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_val_reg <= fin_val_reg;
            m_oc_reg  <= fin_oc_reg;
        end
        case (state_reg)
            tli_pkg::ST_IDLE: begin
                time_reg <= s_query_time;
                col_reg  <= s_column_index;
            end
            tli_pkg::ST_SCAN0: k_reg <= '0;
            tli_pkg::ST_SCAN: begin
                // slide the pair of times along the column
                t1_reg <= t2_reg;
                t2_reg <= rd;
                k_reg  <= k_reg + 1'b1;
                if (scan_eq) begin
                    oc_reg     <= tli_pkg::OC_EXACT;
                    va_row_reg <= k_reg;
                    vb_row_reg <= k_reg;
                end else begin
                    oc_reg     <= scan_between ? tli_pkg::OC_INTERP : tli_pkg::OC_EXTRAP;
                    va_row_reg <= k_reg - 1'b1;
                    vb_row_reg <= k_reg;
                end
            end
            tli_pkg::ST_RDB: va_reg <= rd;
            tli_pkg::ST_CAP: begin
                base_reg    <= rd;
                neg_reg     <= dv[DW] ^ dt[DW] ^ step[DW];
                fin_val_reg <= rd;
                fin_oc_reg  <= (oc_reg != tli_pkg::OC_EXACT && zero_step) ? tli_pkg::OC_ZSTEP
                                                                           : oc_reg;
            end
            tli_pkg::ST_AVG0: begin
                k_reg   <= '0;
                sum_reg <= '0;
            end
            tli_pkg::ST_AVG: begin
                k_reg      <= k_reg + 1'b1;
                sum_reg    <= sum_next;
                base_reg   <= '0;
                neg_reg    <= sum_next[tli_pkg::SUM_W-1];
                fin_oc_reg <= tli_pkg::OC_AVG;
            end
            tli_pkg::ST_DIV: begin
                if (ar_rsp.done) begin
                    fin_val_reg <= res_sat;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_val_reg;
    assign m_outcome      = m_oc_reg;

    `TLI_NEVER(a_we_busy, aclk, aresetn, mem_we && !s_ready, "table write outside idle")
    `TLI_ASSERT(a_start_div, aclk, aresetn, ar_req.start |=> in_div, "divide start not followed")
    `TLI_ASSERT(a_out_load, aclk, aresetn, out_load |=> m_valid_reg, "result beat lost")

endmodule

// ===== sv/tli_ram.sv =====
// ----------------------------------------------------------------------------
// tli_ram
// Single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module tli_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tli_arith.sv =====
// ----------------------------------------------------------------------------
// tli_arith
// Optional serial shift-add multiply, then restoring divide, rounded half up, capped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tli_arith (
    input  logic             aclk,
    input  logic             aresetn,
    input  tli_pkg::ar_req_t req,
    output tli_pkg::ar_rsp_t rsp
);

    localparam logic [tli_pkg::QUOT_W-1:0] CAP = {1'b1, {(tli_pkg::QUOT_W-1){1'b0}}};

    tli_pkg::ar_state_t state_reg, state_next;

    logic [tli_pkg::STEP_W-1:0] cnt_reg;
    logic [tli_pkg::MAG_W-1:0]  a_reg;
    logic [tli_pkg::MAG_W-1:0]  b_reg;
    logic [tli_pkg::MAG_W-1:0]  d_reg;
    logic [tli_pkg::PROD_W-1:0] acc_reg;
    logic [tli_pkg::MAG_W-1:0]  rem_reg;
    logic [tli_pkg::QUOT_W-1:0] q_reg;

    logic [tli_pkg::MAG_W:0]    trial;
    logic                       qbit;
    logic                       last_step;
    logic                       rnd;
    logic                       mul_cnt_ok;
    logic                       quot_ok;

    always_comb begin
        trial = {rem_reg, acc_reg[tli_pkg::PROD_W-1]};
        qbit  = trial >= {1'b0, d_reg};
        rnd   = {rem_reg, 1'b0} >= {1'b0, d_reg};
    end

    always_comb begin
        last_step = 1'b0;
        case (state_reg)
            tli_pkg::AR_MUL: last_step = cnt_reg == tli_pkg::STEP_W'(tli_pkg::MUL_STEPS - 1);
            tli_pkg::AR_DIV: last_step = cnt_reg == tli_pkg::STEP_W'(tli_pkg::DIV_STEPS - 1);
            default:         last_step = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tli_pkg::AR_IDLE: begin
                if (req.start) begin
                    state_next = req.use_mul ? tli_pkg::AR_MUL : tli_pkg::AR_DIV;
                end
            end
            tli_pkg::AR_MUL: if (last_step) state_next = tli_pkg::AR_DIV;
            tli_pkg::AR_DIV: if (last_step) state_next = tli_pkg::AR_FIN;
            tli_pkg::AR_FIN: state_next = tli_pkg::AR_IDLE;
            default:         state_next = tli_pkg::AR_IDLE;
        endcase
    end

    // a quotient at or above 2^40 leaves as the cap itself
    always_comb begin
        rsp.done = state_reg == tli_pkg::AR_FIN;
        rsp.quot = q_reg[tli_pkg::QUOT_W-1] ? CAP : q_reg + tli_pkg::QUOT_W'(rnd);
    end

    always_comb begin
        mul_cnt_ok = (state_reg != tli_pkg::AR_MUL)
                  || (cnt_reg < tli_pkg::STEP_W'(tli_pkg::MUL_STEPS));
        quot_ok    = !rsp.done || (rsp.quot <= CAP);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tli_pkg::AR_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            tli_pkg::AR_IDLE: begin
                cnt_reg <= '0;
                rem_reg <= '0;
                q_reg   <= '0;
                a_reg   <= req.opa[tli_pkg::MAG_W-1:0];
                b_reg   <= req.opb;
                d_reg   <= req.divisor;
                acc_reg <= req.use_mul ? '0 : tli_pkg::PROD_W'(req.opa);
            end
            tli_pkg::AR_MUL: begin
                // one multiplier bit per cycle, MSB first
                acc_reg <= {acc_reg[tli_pkg::PROD_W-2:0], 1'b0}
                         + (b_reg[tli_pkg::MAG_W-1] ? tli_pkg::PROD_W'(a_reg) : '0);
                b_reg   <= {b_reg[tli_pkg::MAG_W-2:0], 1'b0};
                cnt_reg <= last_step ? '0 : cnt_reg + 1'b1;
            end
            tli_pkg::AR_DIV: begin
                acc_reg <= {acc_reg[tli_pkg::PROD_W-2:0], 1'b0};
                rem_reg <= qbit ? tli_pkg::MAG_W'(trial - {1'b0, d_reg})
                                : trial[tli_pkg::MAG_W-1:0];
                // sticky cap once the partial quotient reaches 2^40
                q_reg   <= q_reg[tli_pkg::QUOT_W-1] ? CAP
                                                    : {q_reg[tli_pkg::QUOT_W-2:0], qbit};
                cnt_reg <= cnt_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    `TLI_ASSERT(a_fin_idle, aclk, aresetn, rsp.done |=> state_reg == tli_pkg::AR_IDLE, "arith: no idle")
    `TLI_ASSERT(a_mul_cnt, aclk, aresetn, mul_cnt_ok, "arith: multiply step count overrun")
    `TLI_ASSERT(a_cap, aclk, aresetn, quot_ok, "arith: quotient above cap")

endmodule
